// ===== rtl/core/mlt_pkg.sv =====
package mlt_pkg;

  // fixed field widths
  localparam int IP_W      = 32;
  localparam int PORT_W    = 16;
  localparam int MAC_W     = 48;
  localparam int TIME_W    = 32;
  localparam int SLOT_O_W  = 4;
  localparam int KEY_W     = IP_W + PORT_W + 1;
  localparam int ENTRY_W   = MAC_W + TIME_W;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W     = 5;
  localparam logic [TIME_W-1:0] EXPIRE_RESET = 32'd3600;

  // action codes
  localparam logic ACT_RX = 1'b0;
  localparam logic ACT_TX = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_RX      = 2'd0;
  localparam logic [1:0] KIND_DELIVER = 2'd1;
  localparam logic [1:0] KIND_TX_NONE = 2'd2;

  // learn status codes
  localparam logic [1:0] LS_REFRESH = 2'd0;
  localparam logic [1:0] LS_LEARN   = 2'd1;
  localparam logic [1:0] LS_NO_HDR  = 2'd2;
  localparam logic [1:0] LS_FULL    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RX_RD,
    ST_RX_EV,
    ST_EN_RD,
    ST_EN_EV,
    ST_RX_OUT,
    ST_TX_RD,
    ST_TX_EV,
    ST_TX_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [IP_W-1:0]     ip;
    logic [PORT_W-1:0]   port;
    logic                raw;
    logic [SLOT_O_W-1:0] slot;
    logic                created;
    logic [1:0]          status;
    logic                full;
    logic                last;
  } out_item_t;

endpackage

// ===== rtl/core/mlt_if.sv =====
// input item channel
interface mlt_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] client_addr;
  logic [15:0] client_port;
  logic        client_raw;
  logic [47:0] mac;
  logic        has_header;
  logic [31:0] now;

  modport source (output valid, action, client_addr, client_port, client_raw, mac,
                  has_header, now, input ready);
  modport sink (input valid, action, client_addr, client_port, client_raw, mac,
                has_header, now, output ready);
endinterface

// result item channel
interface mlt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] out_client_addr;
  logic [15:0] out_client_port;
  logic        out_client_raw;
  logic [3:0]  client_slot;
  logic        new_client;
  logic [1:0]  learn_status;
  logic        client_table_full;
  logic        last;

  modport source (output valid, kind, out_client_addr, out_client_port, out_client_raw,
                  client_slot, new_client, learn_status, client_table_full, last,
                  input ready);
  modport sink (input valid, kind, out_client_addr, out_client_port, out_client_raw,
                client_slot, new_client, learn_status, client_table_full, last,
                output ready);
endinterface

// configuration write channel
interface mlt_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] expire_seconds;

  modport source (output valid, expire_seconds, input ready);
  modport sink (input valid, expire_seconds, output ready);
endinterface

// ===== rtl/core/mlt_ram.sv =====
module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/core/mac_learning_table_with_aging_unit.sv =====
// Client forwarding table with aged MAC entries. Client keys sit in one RAM and each client's
// MAC entries sit as one row of a second RAM; valid bits are flip-flops. Each slot visit is a
// read state and then an evaluate state on the single read port of these RAMs, all entries of a
// row compared at once. Every item is accepted in the idle state. A receive then scans slots (up
// to the matching slot, or all CLIENTS when the client is new), then reads the entry row, updates
// it and sends the result, or only sends the result when the client table is full. A transmit
// reads and evaluates each valid slot, skips each free slot, closes in a final state and stalls
// while the result register is occupied. One item is worked on at a time; the next is accepted
// once the last result of the current one is in the result register. No clearing pass is needed
// after reset: a slot's entries are written when its client is created.
module mac_learning_table_with_aging_unit
  import mlt_pkg::*;
#(
  parameter int CLIENTS = 16,
  parameter int ENTRIES = 8
) (
  input logic        clk,
  input logic        rst,
  mlt_req_if.sink    req,
  mlt_rsp_if.source  rsp,
  mlt_cfg_if.sink    cfg
);
  localparam int SW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int EIW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ROW_W = ENTRIES * ENTRY_W;

  state_t state, state_next;

  logic [TIME_W-1:0]  expire_seconds;
  logic [CLIENTS-1:0] slot_valid;

  // item registers
  logic               hdr;
  logic [IP_W-1:0]    ip;
  logic [PORT_W-1:0]  port;
  logic               raw;
  logic [MAC_W-1:0]   mac;
  logic               bcast;
  logic [TIME_W-1:0]  now;
  logic [TIME_W-1:0]  exp_new;

  // scan registers
  logic [SW-1:0]      cnt;
  logic               free_found;
  logic [SW-1:0]      free_slot;
  logic [SW-1:0]      slot;
  logic               created;
  logic [1:0]         status;
  logic               full;
  logic [RES_W-1:0]   n_res;
  logic               pend_valid;
  logic [IP_W-1:0]    pend_ip;
  logic [PORT_W-1:0]  pend_port;
  logic               pend_raw;
  logic [SW-1:0]      pend_slot;

  // result register
  logic               out_valid;
  out_item_t          out_item;
  out_item_t          push_item;
  logic               push;
  logic               out_free;

  // ram ports
  logic               key_we, key_re, ent_we, ent_re;
  logic [SW-1:0]      key_waddr, ent_raddr, ent_waddr;
  logic [KEY_W-1:0]   key_rdata;
  logic [ROW_W-1:0]   ent_rdata, ent_wdata;

  // evaluation signals
  logic               last_slot;
  logic               key_hit;
  logic               cand_ok;
  logic [SW-1:0]      cand_slot;
  logic [ROW_W-1:0]   row_in, rx_row, tx_row;
  logic [ENTRIES-1:0] eq_v, avail_v;
  logic               hit_any, avail_any, active;
  logic [EIW-1:0]     hit_idx, avail_idx;
  logic [1:0]         rx_status;
  logic               emit;
  logic               tx_step;
  logic [TIME_W:0]    exp_sum;
  logic [SW+SLOT_O_W-1:0] slot_ext, pend_ext;

  mlt_ram #(.WIDTH(KEY_W), .DEPTH(CLIENTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata ({ip, port, raw}),
    .re    (key_re),
    .raddr (cnt),
    .rdata (key_rdata)
  );

  mlt_ram #(.WIDTH(ROW_W), .DEPTH(CLIENTS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign out_free  = !out_valid || rsp.ready;
  assign last_slot = (cnt == SW'(CLIENTS - 1));
  assign exp_sum   = {1'b0, req.now} + {1'b0, expire_seconds};

  // key lookup and free slot choice
  assign key_hit   = slot_valid[cnt] && (key_rdata == {ip, port, raw});
  assign cand_ok   = free_found || !slot_valid[cnt];
  assign cand_slot = free_found ? free_slot : cnt;

  // entry row compares, all entries at once
  assign row_in = created ? '0 : ent_rdata;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      eq_v[i]    = row_in[i*ENTRY_W +: MAC_W] == mac;
      avail_v[i] = now > row_in[i*ENTRY_W+MAC_W +: TIME_W];
    end
    hit_any   = |eq_v;
    avail_any = |avail_v;
    hit_idx   = '0;
    avail_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (eq_v[i]) begin
        hit_idx = EIW'(i);
      end
      if (avail_v[i]) begin
        avail_idx = EIW'(i);
      end
    end
  end

  // receive row update
  always_comb begin
    rx_row = row_in;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hdr && hit_any && hit_idx == EIW'(i)) begin
        rx_row[i*ENTRY_W+MAC_W +: TIME_W] = exp_new;
      end else if (hdr && !hit_any && avail_any && avail_idx == EIW'(i)) begin
        rx_row[i*ENTRY_W +: MAC_W]          = mac;
        rx_row[i*ENTRY_W+MAC_W +: TIME_W] = exp_new;
      end
    end
    if (!hdr) begin
      rx_status = LS_NO_HDR;
    end else if (hit_any) begin
      rx_status = LS_REFRESH;
    end else if (avail_any) begin
      rx_status = LS_LEARN;
    end else begin
      rx_status = LS_FULL;
    end
  end

  // transmit row refresh and liveness
  always_comb begin
    tx_row = row_in;
    active = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (eq_v[i]) begin
        tx_row[i*ENTRY_W+MAC_W +: TIME_W] = exp_new;
      end
      if (tx_row[i*ENTRY_W+MAC_W +: TIME_W] > now) begin
        active = 1'b1;
      end
    end
    emit    = active && (bcast || hit_any) && (n_res < RES_W'(MAX_RESULTS));
    tx_step = !(emit && pend_valid && !out_free);
  end

  assign slot_ext = {{SLOT_O_W{1'b0}}, slot};
  assign pend_ext = {{SLOT_O_W{1'b0}}, pend_slot};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (req.action == ACT_TX) ? ST_TX_RD : ST_RX_RD;
        end
      end
      ST_RX_RD: state_next = ST_RX_EV;
      ST_RX_EV: begin
        if (key_hit || (last_slot && cand_ok)) begin
          state_next = ST_EN_RD;
        end else if (last_slot) begin
          state_next = ST_RX_OUT;
        end else begin
          state_next = ST_RX_RD;
        end
      end
      ST_EN_RD: state_next = ST_EN_EV;
      ST_EN_EV: state_next = ST_RX_OUT;
      ST_RX_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TX_RD: begin
        if (slot_valid[cnt]) begin
          state_next = ST_TX_EV;
        end else if (last_slot) begin
          state_next = ST_TX_FIN;
        end
      end
      ST_TX_EV: begin
        if (tx_step) begin
          state_next = last_slot ? ST_TX_FIN : ST_TX_RD;
        end
      end
      ST_TX_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    key_re    = 1'b0;
    key_we    = 1'b0;
    key_waddr = cand_slot;
    ent_re    = 1'b0;
    ent_raddr = cnt;
    ent_we    = 1'b0;
    ent_waddr = slot;
    ent_wdata = rx_row;
    push      = 1'b0;
    push_item = '0;
    unique case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_RX_RD: key_re = 1'b1;
      ST_RX_EV: key_we = !key_hit && last_slot && cand_ok;
      ST_EN_RD: begin
        ent_re    = 1'b1;
        ent_raddr = slot;
      end
      ST_EN_EV: ent_we = created || hdr;
      ST_RX_OUT: begin
        push      = out_free;
        push_item = '{kind: KIND_RX, ip: ip, port: port, raw: raw,
                      slot: slot_ext[SLOT_O_W-1:0], created: created,
                      status: status, full: full, last: 1'b1};
      end
      ST_TX_RD: begin
        key_re = slot_valid[cnt];
        ent_re = slot_valid[cnt];
      end
      ST_TX_EV: begin
        ent_we    = tx_step;
        ent_waddr = cnt;
        ent_wdata = tx_row;
        push      = tx_step && emit && pend_valid;
        push_item = '{kind: KIND_DELIVER, ip: pend_ip, port: pend_port, raw: pend_raw,
                      slot: pend_ext[SLOT_O_W-1:0], created: 1'b0,
                      status: LS_REFRESH, full: 1'b0, last: 1'b0};
      end
      ST_TX_FIN: begin
        push = out_free;
        if (pend_valid) begin
          push_item = '{kind: KIND_DELIVER, ip: pend_ip, port: pend_port, raw: pend_raw,
                        slot: pend_ext[SLOT_O_W-1:0], created: 1'b0,
                        status: LS_REFRESH, full: 1'b0, last: 1'b1};
        end else begin
          push_item = '{kind: KIND_TX_NONE, ip: '0, port: '0, raw: 1'b0, slot: '0,
                        created: 1'b0, status: LS_REFRESH, full: 1'b0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      expire_seconds <= EXPIRE_RESET;
      slot_valid     <= '0;
      out_valid      <= 1'b0;
      pend_valid     <= 1'b0;
      free_found     <= 1'b0;
      n_res          <= '0;
      cnt            <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        expire_seconds <= cfg.expire_seconds;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt        <= '0;
          free_found <= 1'b0;
          n_res      <= '0;
          pend_valid <= 1'b0;
        end
        ST_RX_EV: begin
          if (!key_hit) begin
            if (!slot_valid[cnt] && !free_found) begin
              free_found <= 1'b1;
            end
            if (last_slot && cand_ok) begin
              slot_valid[cand_slot] <= 1'b1;
            end
            cnt <= cnt + SW'(1);
          end
        end
        ST_TX_RD: begin
          if (!slot_valid[cnt]) begin
            cnt <= cnt + SW'(1);
          end
        end
        ST_TX_EV: begin
          if (tx_step) begin
            if (!active) begin
              slot_valid[cnt] <= 1'b0;
            end
            if (emit) begin
              pend_valid <= 1'b1;
              n_res      <= n_res + RES_W'(1);
            end
            cnt <= cnt + SW'(1);
          end
        end
        ST_TX_FIN: begin
          if (out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      out_item <= push_item;
    end
    unique case (state)
      ST_IDLE: begin
        hdr     <= req.has_header;
        ip      <= req.client_addr;
        port    <= req.client_port;
        raw     <= req.client_raw;
        mac     <= (req.action == ACT_TX && !req.has_header) ? '1 : req.mac;
        bcast   <= (req.action == ACT_TX) && (!req.has_header || req.mac == '1);
        now     <= req.now;
        exp_new <= exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
        created <= 1'b0;
        full    <= 1'b0;
      end
      ST_RX_EV: begin
        if (key_hit) begin
          slot <= cnt;
        end else begin
          if (!slot_valid[cnt] && !free_found) begin
            free_slot <= cnt;
          end
          if (last_slot && cand_ok) begin
            slot    <= cand_slot;
            created <= 1'b1;
          end else if (last_slot) begin
            slot   <= '0;
            full   <= 1'b1;
            status <= hdr ? LS_FULL : LS_NO_HDR;
          end
        end
      end
      ST_EN_EV: status <= rx_status;
      ST_TX_EV: begin
        if (tx_step && emit) begin
          pend_ip   <= key_rdata[KEY_W-1 -: IP_W];
          pend_port <= key_rdata[PORT_W:1];
          pend_raw  <= key_rdata[0];
          pend_slot <= cnt;
        end
      end
      default: ;
    endcase
  end

  assign cfg.ready             = 1'b1;
  assign rsp.valid             = out_valid;
  assign rsp.kind              = out_item.kind;
  assign rsp.out_client_addr   = out_item.ip;
  assign rsp.out_client_port   = out_item.port;
  assign rsp.out_client_raw    = out_item.raw;
  assign rsp.client_slot       = out_item.slot;
  assign rsp.new_client        = out_item.created;
  assign rsp.learn_status      = out_item.status;
  assign rsp.client_table_full = out_item.full;
  assign rsp.last              = out_item.last;

  // receive gives exactly one, final item
  a_rx_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == KIND_RX |-> rsp.last)
    else $error("receive result without last");

  // delivery items carry no receive status
  a_deliver_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == KIND_DELIVER |->
      !rsp.new_client && !rsp.client_table_full && rsp.learn_status == LS_REFRESH)
    else $error("delivery item with receive status");

  // a full table never creates a client
  a_full_no_create: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.client_table_full |-> !rsp.new_client)
    else $error("client created while table full");

  // accepted item leaves idle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != ST_IDLE)
    else $error("item accepted without starting work");

  // result count bounded
  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    n_res <= RES_W'(MAX_RESULTS))
    else $error("result count beyond cap");
endmodule

// ===== sim/mlt_tb_if.sv =====
`timescale 1ns / 100ps

// item carried from the stimulus queue to the driver
package mlt_tb_pkg;
  typedef struct {
    logic        action;
    logic [31:0] addr;
    logic [15:0] port;
    logic        raw;
    logic [47:0] mac;
    logic        hdr;
    logic [31:0] now;
  } frame_t;
endpackage

// ===== sim/mac_learning_table_with_aging_unit_test.sv =====
`timescale 1ns / 100ps

module mac_learning_table_with_aging_unit_test;
  import mlt_pkg::*;
  import mlt_tb_pkg::*;

  localparam int CLIENTS = 16;
  localparam int ENTRIES = 8;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mlt_req_if req();
  mlt_rsp_if rsp();
  mlt_cfg_if cfg();

  mac_learning_table_with_aging_unit #(.CLIENTS(CLIENTS), .ENTRIES(ENTRIES)) uut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted table contents
  logic [31:0] lifetime;
  logic        tbl_valid [CLIENTS];
  logic [31:0] tbl_ip [CLIENTS];
  logic [15:0] tbl_port [CLIENTS];
  logic        tbl_raw [CLIENTS];
  logic [47:0] tbl_mac [CLIENTS][ENTRIES];
  logic [31:0] tbl_exp [CLIENTS][ENTRIES];

  frame_t    pending_frames[$];
  out_item_t expected_rows[$];
  int        errors = 0;
  int        cycles = 0;
  int        rows_seen = 0;
  bit        drive_steady = 0;
  bit        hold_off = 0;
  bit        recv_steady = 0;
  bit        in_taken = 0;

  function automatic logic [31:0] aged(logic [31:0] now);
    logic [32:0] s;
    s = {1'b0, now} + {1'b0, lifetime};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic out_item_t mk_row(logic [1:0] k, logic [31:0] ip, logic [15:0] pt,
                                       logic rw, int sl, logic cr, logic [1:0] st,
                                       logic fl, logic ls);
    out_item_t r;
    r.kind = k; r.ip = ip; r.port = pt; r.raw = rw; r.slot = sl[3:0];
    r.created = cr; r.status = st; r.full = fl; r.last = ls;
    return r;
  endfunction

  // compute result rows of one accepted frame, updating the table copy
  task automatic predict_frame(frame_t f);
    int slot, freeslot, hit, avail, n;
    logic created, match, active, bcast;
    logic [1:0] st;
    logic [47:0] dst;
    slot = -1; freeslot = -1; hit = -1; avail = -1; n = 0; created = 1'b0;
    if (f.action == ACT_RX) begin
      for (int c = 0; c < CLIENTS; c++) begin
        if (tbl_valid[c] && tbl_ip[c] == f.addr && tbl_port[c] == f.port &&
            tbl_raw[c] == f.raw) begin
          slot = c;
          break;
        end
        if (!tbl_valid[c] && freeslot < 0) freeslot = c;
      end
      if (slot < 0 && freeslot < 0) begin
        expected_rows.push_back(mk_row(KIND_RX, f.addr, f.port, f.raw, 0, 1'b0,
                                       f.hdr ? LS_FULL : LS_NO_HDR, 1'b1, 1'b1));
        return;
      end
      if (slot < 0) begin
        slot = freeslot; created = 1'b1;
        tbl_valid[slot] = 1'b1; tbl_ip[slot] = f.addr;
        tbl_port[slot] = f.port; tbl_raw[slot] = f.raw;
        for (int i = 0; i < ENTRIES; i++) begin
          tbl_mac[slot][i] = '0; tbl_exp[slot][i] = '0;
        end
      end
      if (!f.hdr) st = LS_NO_HDR;
      else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_mac[slot][i] == f.mac) begin
            hit = i;
            break;
          end
          if (avail < 0 && f.now > tbl_exp[slot][i]) avail = i;
        end
        if (hit >= 0) begin
          tbl_exp[slot][hit] = aged(f.now); st = LS_REFRESH;
        end else if (avail >= 0) begin
          tbl_mac[slot][avail] = f.mac; tbl_exp[slot][avail] = aged(f.now); st = LS_LEARN;
        end else st = LS_FULL;
      end
      expected_rows.push_back(mk_row(KIND_RX, f.addr, f.port, f.raw, slot, created, st,
                                     1'b0, 1'b1));
    end else begin
      dst = f.hdr ? f.mac : 48'hFFFF_FFFF_FFFF;
      bcast = (dst == 48'hFFFF_FFFF_FFFF);
      for (int c = 0; c < CLIENTS; c++) begin
        if (!tbl_valid[c]) continue;
        match = bcast; active = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_mac[c][i] == dst) begin
            tbl_exp[c][i] = aged(f.now); match = 1'b1;
          end
          if (tbl_exp[c][i] > f.now) active = 1'b1;
        end
        if (!active) tbl_valid[c] = 1'b0;
        else if (match && n < MAX_RESULTS) begin
          expected_rows.push_back(mk_row(KIND_DELIVER, tbl_ip[c], tbl_port[c], tbl_raw[c],
                                         c, 1'b0, LS_REFRESH, 1'b0, 1'b0));
          n++;
        end
      end
      if (n == 0) expected_rows.push_back(mk_row(KIND_TX_NONE, 32'd0, 16'd0, 1'b0, 0, 1'b0,
                                                 LS_REFRESH, 1'b0, 1'b1));
      else expected_rows[$].last = 1'b1;
    end
  endtask

  // driver: offers queued frames at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || in_taken) begin
      if (pending_frames.size() > 0 && (drive_steady || $urandom_range(99) >= 25)) begin
        req.valid       <= 1'b1;
        req.action      <= pending_frames[0].action;
        req.client_addr <= pending_frames[0].addr;
        req.client_port <= pending_frames[0].port;
        req.client_raw  <= pending_frames[0].raw;
        req.mac         <= pending_frames[0].mac;
        req.has_header  <= pending_frames[0].hdr;
        req.now         <= pending_frames[0].now;
        void'(pending_frames.pop_front());
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver ready
  always @(negedge clk) begin
    if (rst || hold_off) rsp.ready <= 1'b0;
    else rsp.ready <= recv_steady || ($urandom_range(99) >= 25);
  end

  // monitor: predict on request accept, check on result accept
  always @(posedge clk) begin
    out_item_t got, want;
    cycles <= cycles + 1;
    in_taken <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready) begin
      predict_frame('{req.action, req.client_addr, req.client_port, req.client_raw,
                      req.mac, req.has_header, req.now});
    end
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.kind, rsp.out_client_addr, rsp.out_client_port, rsp.out_client_raw,
              rsp.client_slot, rsp.new_client, rsp.learn_status, rsp.client_table_full,
              rsp.last};
      rows_seen++;
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_rows.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic frame_t rx_frame(logic [31:0] ip, logic [15:0] pt, logic rw,
                                      logic [47:0] mac, logic hdr, logic [31:0] now);
    return '{ACT_RX, ip, pt, rw, mac, hdr, now};
  endfunction

  function automatic frame_t tx_frame(logic [47:0] mac, logic hdr, logic [31:0] now);
    return '{ACT_TX, 32'($urandom), 16'($urandom), 1'($urandom_range(1)), mac, hdr, now};
  endfunction

  task automatic write_lifetime(logic [31:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.expire_seconds <= v;
    do @(posedge clk); while (!cfg.ready);
    lifetime = v;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain;
    wait (pending_frames.size() == 0);
    @(posedge clk);
    while (req.valid || expected_rows.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // random frame drawn from a small pool of clients and MACs so traffic hits state
  function automatic frame_t random_frame(logic [31:0] t);
    logic [31:0] ip;
    logic [47:0] mac;
    int k, m;
    k = $urandom_range(19);
    m = $urandom_range(11);
    ip = (k < 18) ? 32'h0A00_0000 + k : $urandom;
    mac = (m < 10) ? {$urandom, 16'h0} | m : 48'({$urandom, $urandom});
    if (m == 11 && $urandom_range(1)) mac = 48'hFFFF_FFFF_FFFF;
    if ($urandom_range(9) < 6)
      return rx_frame(ip, (k < 18) ? 16'(k % 3) : 16'($urandom), k[0], mac[47:0],
                      $urandom_range(9) != 0, t);
    return tx_frame(mac, $urandom_range(7) != 0, t);
  endfunction

  initial begin
    logic [31:0] t;
    lifetime = EXPIRE_RESET;
    for (int c = 0; c < CLIENTS; c++) tbl_valid[c] = 0;
    req.valid = 0; req.action = 0; req.client_addr = 0; req.client_port = 0;
    req.client_raw = 0; req.mac = 0; req.has_header = 0; req.now = 0;
    rsp.ready = 0; cfg.valid = 0; cfg.expire_seconds = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, zero mac fresh entry, no header, broadcast, saturation
    write_lifetime(32'd1);
    pending_frames.push_back(rx_frame(32'hFFFF_FFFF, 16'hFFFF, 1, 48'h0, 1, 32'd0));
    pending_frames.push_back(rx_frame(32'h0, 16'h0, 0, 48'hFFFF_FFFF_FFFF, 1, 32'd5));
    pending_frames.push_back(rx_frame(32'h0, 16'h0, 0, 48'h1, 0, 32'd5));
    pending_frames.push_back(tx_frame(48'hFFFF_FFFF_FFFF, 1, 32'd5));
    pending_frames.push_back(tx_frame(48'h0, 0, 32'd5));
    pending_frames.push_back(tx_frame(48'h1234, 1, 32'd5));
    pending_frames.push_back(tx_frame(48'h0, 1, 32'd100));
    drain();
    write_lifetime(32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++)
      pending_frames.push_back(rx_frame(32'h0B00_0000, 16'h7, 0, 48'h100 + i, 1, 32'd10));
    for (int c = 0; c < 17; c++)
      pending_frames.push_back(rx_frame(32'h0C00_0000 + c, 16'h1, 1, 48'h5, c[0], 32'd20));
    pending_frames.push_back(tx_frame(48'h5, 1, 32'hFFFF_FFFE));
    pending_frames.push_back(tx_frame(48'hFFFF_FFFF_FFFF, 0, 32'hFFFF_FFFF));
    drain();

    // random phases with varied lifetimes; time moves forward with jumps
    t = 32'd1000;
    for (int ph = 0; ph < 4; ph++) begin
      write_lifetime(ph == 0 ? EXPIRE_RESET : ph == 1 ? 32'd30 : ph == 2 ? 32'd1 : $urandom);
      drive_steady = (ph == 1);
      recv_steady = (ph == 1);
      for (int i = 0; i < 75; i++) begin
        t = t + $urandom_range(4) + (($urandom_range(19) == 0) ? $urandom_range(100) : 0);
        pending_frames.push_back(random_frame(t));
      end
      if (ph == 2) begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end
    t = 32'hFFFF_FF00;
    for (int i = 0; i < 20; i++) pending_frames.push_back(random_frame(t + i));
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
